/* hw/rtl/lqrsfc_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// LQR state feedback package
// Word types, command kinds and reply codes shared by the controller modules.
// ----------------------------------------------------------------------------
package lqrsfc_pkg;

    localparam int unsigned NumStates = 4;
    localparam int unsigned NumGains  = 8;

    localparam logic [1:0] KIND_TICK  = 2'd0;
    localparam logic [1:0] KIND_START = 2'd1;
    localparam logic [1:0] KIND_MEAS  = 2'd2;
    localparam logic [1:0] KIND_REQ   = 2'd3;

    localparam logic [2:0] REPLY_STARTED  = 3'd0;
    localparam logic [2:0] REPLY_ALREADY  = 3'd1;
    localparam logic [2:0] REPLY_STORED   = 3'd2;
    localparam logic [2:0] REPLY_DRIVES   = 3'd3;
    localparam logic [2:0] REPLY_INACTIVE = 3'd4;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [31:0] meas_0;
        logic signed [31:0] meas_1;
        logic signed [31:0] meas_2;
        logic signed [31:0] meas_3;
    } t_item;

    typedef struct packed {
        logic [2:0]         reply;
        logic signed [31:0] drive_a;
        logic signed [31:0] drive_b;
        logic [31:0]        elapsed_ms;
    } t_result;

    typedef logic [NumStates-1:0][31:0] t_states;
    typedef logic [NumGains-1:0][31:0]  t_gains;

    typedef struct packed {
        logic [2:0]  reply;
        t_states     states;
        logic [31:0] elapsed_ms;
    } t_job;

endpackage
`default_nettype wire

/* hw/rtl/lqrsfc_queue.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// LQR state feedback word queue
// Small first-in first-out buffer of words held in registers.
// ----------------------------------------------------------------------------
module lqrsfc_queue #(
    parameter type         t_word = logic,
    parameter int unsigned DEPTH  = 4
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_word i_data,
    output logic       o_full,
    input  wire logic  i_pop,
    output logic       o_empty,
    output t_word      o_data
);

    localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CntW = $clog2(DEPTH + 1);

    t_word            r_mem [DEPTH];
    logic [PtrW-1:0]  r_wr_ptr;
    logic [PtrW-1:0]  r_rd_ptr;
    logic [CntW-1:0]  r_count;
    logic             w_do_push;
    logic             w_do_pop;

    assign o_full    = (r_count == CntW'(DEPTH));
    assign o_empty   = (r_count == '0);
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;
    assign o_data    = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_do_push) begin
                r_wr_ptr <= (r_wr_ptr == PtrW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PtrW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_do_push && !w_do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_do_pop && !w_do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

/* hw/rtl/lqrsfc_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// LQR state feedback command front end
// Accepts command words, keeps time, activity and the state estimate, and
// issues one job per command that needs a reply.
// ----------------------------------------------------------------------------
module lqrsfc_front
    import lqrsfc_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_item i_item,
    output logic       o_full,
    output logic       o_job_push,
    output t_job       o_job,
    input  wire logic  i_job_full
);

    logic [31:0] r_tick;
    logic [31:0] r_start;
    logic        r_active;
    t_states     r_states;
    logic        w_accept;

    assign o_full     = i_job_full;
    assign w_accept   = i_push && !i_job_full;
    assign o_job_push = w_accept && (i_item.kind != KIND_TICK);

    always_comb begin
        o_job.states     = r_states;
        o_job.elapsed_ms = r_tick - r_start;
        unique case (i_item.kind)
            KIND_START: o_job.reply = r_active ? REPLY_ALREADY : REPLY_STARTED;
            KIND_MEAS:  o_job.reply = r_active ? REPLY_STORED : REPLY_INACTIVE;
            KIND_REQ:   o_job.reply = r_active ? REPLY_DRIVES : REPLY_INACTIVE;
            default:    o_job.reply = REPLY_INACTIVE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick   <= '0;
            r_start  <= '0;
            r_active <= 1'b0;
            r_states <= '0;
        end else if (w_accept) begin
            unique case (i_item.kind)
                KIND_TICK: begin
                    r_tick <= r_tick + 1'b1;
                end
                KIND_START: begin
                    if (!r_active) begin
                        r_start  <= r_tick;
                        r_active <= 1'b1;
                    end
                end
                KIND_MEAS: begin
                    if (r_active) begin
                        r_states <= {i_item.meas_3, i_item.meas_2,
                                     i_item.meas_1, i_item.meas_0};
                    end
                end
                default: begin
                end
            endcase
        end
    end

endmodule
`default_nettype wire

/* hw/rtl/lqrsfc_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// LQR state feedback drive pipeline
// Three-stage multiply, add and saturate pipeline that turns jobs into
// result words.
// ----------------------------------------------------------------------------
module lqrsfc_back
    import lqrsfc_pkg::*;
#(
    parameter int unsigned FRAC_BITS = 16
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire t_gains i_gains,
    input  wire logic   i_job_valid,
    input  wire t_job   i_job,
    output logic        o_job_pop,
    output logic        o_res_push,
    output t_result     o_res,
    input  wire logic   i_res_full
);

    localparam logic signed [66:0] MaxDrive = 67'sd2147483647;
    localparam logic signed [66:0] MinDrive = -67'sd2147483648;

    logic               w_en;
    logic               r_v1;
    logic               r_v2;
    logic               r_v3;
    logic signed [63:0] r_prod [2][NumStates];
    logic signed [64:0] r_pair [2][2];
    logic [2:0]         r_reply1;
    logic [2:0]         r_reply2;
    logic [31:0]        r_elapsed1;
    logic [31:0]        r_elapsed2;
    t_result            r_res;
    t_result            w_res;

    function automatic logic signed [31:0] sat_drive(input logic signed [64:0] a,
                                                     input logic signed [64:0] b);
        logic signed [65:0] sum;
        logic signed [65:0] shifted;
        logic signed [66:0] neg;
        begin
            sum     = 66'(a) + 66'(b);
            shifted = sum >>> FRAC_BITS;
            neg     = -(67'(shifted));
            if (neg > MaxDrive) begin
                sat_drive = 32'sh7FFFFFFF;
            end else if (neg < MinDrive) begin
                sat_drive = 32'sh80000000;
            end else begin
                sat_drive = neg[31:0];
            end
        end
    endfunction

    assign w_en       = !r_v3 || !i_res_full;
    assign o_job_pop  = w_en && i_job_valid;
    assign o_res_push = r_v3 && !i_res_full;
    assign o_res      = r_res;

    always_comb begin
        w_res.reply = r_reply2;
        if (r_reply2 == REPLY_DRIVES) begin
            w_res.drive_a    = sat_drive(r_pair[0][0], r_pair[0][1]);
            w_res.drive_b    = sat_drive(r_pair[1][0], r_pair[1][1]);
            w_res.elapsed_ms = r_elapsed2;
        end else begin
            w_res.drive_a    = '0;
            w_res.drive_b    = '0;
            w_res.elapsed_ms = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int r = 0; r < 2; r++) begin
                for (int e = 0; e < NumStates; e++) begin
                    r_prod[r][e] <= $signed(i_gains[r*NumStates+e]) *
                                    $signed(i_job.states[e]);
                end
                r_pair[r][0] <= 65'(r_prod[r][0]) + 65'(r_prod[r][1]);
                r_pair[r][1] <= 65'(r_prod[r][2]) + 65'(r_prod[r][3]);
            end
            r_reply1   <= i_job.reply;
            r_elapsed1 <= i_job.elapsed_ms;
            r_reply2   <= r_reply1;
            r_elapsed2 <= r_elapsed1;
            r_res      <= w_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (w_en) begin
            r_v1 <= i_job_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

endmodule
`default_nettype wire

/* hw/rtl/lqr_state_feedback_controller.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// LQR state feedback controller
// Command-driven two-drive, four-state steady-state LQR controller.
// ----------------------------------------------------------------------------
// The block takes one command word per clock while its job queue has room
// and gives one result word per clock while results are popped. Ticks,
// starts and measurements are handled in the cycle they are accepted; each
// command that answers is queued and passes a three-stage multiply, add and
// saturate pipeline. The user must write gains through the register port
// only while no command is in flight; the block does not enforce it.
// ----------------------------------------------------------------------------
module lqr_state_feedback_controller
    import lqrsfc_pkg::*;
#(
    parameter int unsigned FRAC_BITS = 16,
    parameter int unsigned MID_DEPTH = 4,
    parameter int unsigned OUT_DEPTH = 2
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        push,
    input  wire t_item       i_item,
    output logic             full,
    input  wire logic        pop,
    output logic             empty,
    output t_result          o_result,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    t_gains  r_gains;
    logic    w_job_push;
    t_job    w_job_in;
    logic    w_mid_full;
    logic    w_mid_empty;
    t_job    w_job_out;
    logic    w_job_pop;
    logic    w_res_push;
    t_result w_res;
    logic    w_out_full;

    assign pready = 1'b1;
    assign prdata = r_gains[paddr[4:2]];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gains <= '0;
        end else if (psel && penable && pwrite) begin
            r_gains[paddr[4:2]] <= pwdata;
        end
    end

    lqrsfc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_item     (i_item),
        .o_full     (full),
        .o_job_push (w_job_push),
        .o_job      (w_job_in),
        .i_job_full (w_mid_full)
    );

    lqrsfc_queue #(
        .t_word (t_job),
        .DEPTH  (MID_DEPTH)
    ) u_mid_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_job_push),
        .i_data  (w_job_in),
        .o_full  (w_mid_full),
        .i_pop   (w_job_pop),
        .o_empty (w_mid_empty),
        .o_data  (w_job_out)
    );

    lqrsfc_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_gains     (r_gains),
        .i_job_valid (!w_mid_empty),
        .i_job       (w_job_out),
        .o_job_pop   (w_job_pop),
        .o_res_push  (w_res_push),
        .o_res       (w_res),
        .i_res_full  (w_out_full)
    );

    lqrsfc_queue #(
        .t_word (t_result),
        .DEPTH  (OUT_DEPTH)
    ) u_out_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_data  (w_res),
        .o_full  (w_out_full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (o_result)
    );

    a_zero_unused_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_result.reply != REPLY_DRIVES) |->
        (o_result.drive_a == '0 && o_result.drive_b == '0 && o_result.elapsed_ms == '0))
        else $error("non-drive reply carries nonzero fields");

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_push |-> !w_out_full)
        else $error("result pushed into full output queue");

    a_pop_only_with_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_job_pop |-> !w_mid_empty)
        else $error("job popped from empty queue");

    a_tick_no_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !full && i_item.kind == KIND_TICK) |-> !w_job_push)
        else $error("tick produced a job");

endmodule
`default_nettype wire

/* tb/sv/lqr_state_feedback_controller_test.sv */
// ----------------------------------------------------------------------------
// LQR state feedback controller testbench
// Drives command words into the controller and checks every result word
// against table values or an in-bench model of gains, state and drives.
// A short table covers inactive replies, start handling, saturation and
// rounding, then random command sequences run under several gain settings
// with random stalls on both handshakes. Gains are read back after writing.
// ----------------------------------------------------------------------------
module lqr_state_feedback_controller_test;
    import lqrsfc_pkg::*;

    localparam int FRAC        = 16;
    localparam int NUM_RANDOM  = 800;
    localparam int PHASE_LEN   = 200;
    localparam int SETTLE      = 8;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        bit      cfg;
        t_gains  gains;
        t_item   word;
        bit      typed;
        t_result exp;
    } t_dir_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    t_item       i_item = '0;
    logic        full;
    logic        pop = 1'b0;
    logic        empty;
    t_result     o_result;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    bit          typed_flag = 1'b0;
    t_result     typed_word = '0;
    bit          calm = 1'b0;

    logic signed [31:0] gain_tbl [NumGains];
    logic signed [31:0] state_est [NumStates];
    logic [31:0]        tick_cnt = '0;
    logic [31:0]        start_ms = '0;
    bit                 is_active = 1'b0;
    t_result            pending_results [$];

    int errors = 0;
    int cycle_cnt = 0;
    int n_ticks = 0, n_starts = 0, n_meas = 0, n_reqs = 0;
    int n_checked = 0, n_saturated = 0, n_gain_sets = 0;
    int stall_left = 0;

    lqr_state_feedback_controller DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .i_item   (i_item),
        .full     (full),
        .pop      (pop),
        .empty    (empty),
        .o_result (o_result),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("** lqr_state_feedback_controller: FAILED **");
            $finish;
        end
    end

    function automatic logic signed [31:0] drive_value(input int row);
        logic signed [65:0] acc;
        logic signed [65:0] g;
        logic signed [65:0] x;
        logic signed [65:0] q;
        acc = '0;
        for (int e = 0; e < NumStates; e++) begin
            g = gain_tbl[row * NumStates + e];
            x = state_est[e];
            acc = acc + g * x;
        end
        q = -(acc >>> FRAC);
        if (q > 66'sd2147483647) begin
            return 32'sh7fffffff;
        end
        if (q < -66'sd2147483648) begin
            return 32'sh80000000;
        end
        return q[31:0];
    endfunction

    task automatic apply_command(input t_item w, output bit has, output t_result r);
        r = '0;
        has = 1'b1;
        case (w.kind)
            KIND_TICK: begin
                tick_cnt = tick_cnt + 32'd1;
                has = 1'b0;
                n_ticks++;
            end
            KIND_START: begin
                n_starts++;
                if (is_active) begin
                    r.reply = REPLY_ALREADY;
                end else begin
                    start_ms = tick_cnt;
                    is_active = 1'b1;
                    r.reply = REPLY_STARTED;
                end
            end
            KIND_MEAS: begin
                n_meas++;
                if (!is_active) begin
                    r.reply = REPLY_INACTIVE;
                end else begin
                    state_est[0] = w.meas_0;
                    state_est[1] = w.meas_1;
                    state_est[2] = w.meas_2;
                    state_est[3] = w.meas_3;
                    r.reply = REPLY_STORED;
                end
            end
            default: begin
                n_reqs++;
                if (!is_active) begin
                    r.reply = REPLY_INACTIVE;
                end else begin
                    r.reply      = REPLY_DRIVES;
                    r.drive_a    = drive_value(0);
                    r.drive_b    = drive_value(1);
                    r.elapsed_ms = tick_cnt - start_ms;
                end
            end
        endcase
    endtask

    always @(posedge i_clk) begin : monitor
        t_result got;
        t_result want;
        t_result pred;
        bit      has;
        if (i_rst_n) begin
            if (pop && !empty) begin
                got = o_result;
                n_checked++;
                if (got.reply == REPLY_DRIVES &&
                    (got.drive_a == 32'sh7fffffff || got.drive_a == 32'sh80000000 ||
                     got.drive_b == 32'sh7fffffff || got.drive_b == 32'sh80000000)) begin
                    n_saturated++;
                end
                if (pending_results.size() == 0) begin
                    $error("result word with no expectation: reply %0d", got.reply);
                    errors++;
                end else begin
                    want = pending_results.pop_front();
                    if (got.reply !== want.reply) begin
                        $error("reply: expected %0d, got %0d", want.reply, got.reply);
                        errors++;
                    end
                    if (got.drive_a !== want.drive_a) begin
                        $error("drive_a: expected %h, got %h", want.drive_a, got.drive_a);
                        errors++;
                    end
                    if (got.drive_b !== want.drive_b) begin
                        $error("drive_b: expected %h, got %h", want.drive_b, got.drive_b);
                        errors++;
                    end
                    if (got.elapsed_ms !== want.elapsed_ms) begin
                        $error("elapsed_ms: expected %0d, got %0d",
                               want.elapsed_ms, got.elapsed_ms);
                        errors++;
                    end
                end
            end
            if (push && !full) begin
                apply_command(i_item, has, pred);
                if (has) begin
                    pending_results.push_back(typed_flag ? typed_word : pred);
                end
            end
            if (psel && penable && pwrite && pready) begin
                gain_tbl[paddr[4:2]] = pwdata;
            end
        end
    end

    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            pop <= 1'b0;
            stall_left--;
        end else if (!calm && $urandom_range(0, 9) == 0) begin
            pop <= 1'b0;
            stall_left = $urandom_range(1, 18) - 1;
        end else begin
            pop <= 1'b1;
        end
    end

    function automatic logic [31:0] rand_fixed();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(0, 7))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return 32'h0;
            3: return {{24{r[7]}}, r[7:0]};
            4, 5: return {{12{r[19]}}, r[19:0]};
            default: return r;
        endcase
    endfunction

    function automatic t_item mk_item(input logic [1:0] k, input logic [31:0] m0,
                                      input logic [31:0] m1, input logic [31:0] m2,
                                      input logic [31:0] m3);
        t_item w;
        w.kind   = k;
        w.meas_0 = m0;
        w.meas_1 = m1;
        w.meas_2 = m2;
        w.meas_3 = m3;
        return w;
    endfunction

    function automatic t_result mk_res(input logic [2:0] rep, input logic [31:0] ms);
        t_result r;
        r = '0;
        r.reply      = rep;
        r.elapsed_ms = ms;
        return r;
    endfunction

    function automatic t_item rand_item(input logic [1:0] k);
        return mk_item(k, rand_fixed(), rand_fixed(), rand_fixed(), rand_fixed());
    endfunction

    task automatic send_word(input t_item w, input bit typed, input t_result tv);
        push       <= 1'b1;
        i_item     <= w;
        typed_flag <= typed;
        typed_word <= tv;
        do @(posedge i_clk); while (full);
        if (!calm && $urandom_range(0, 7) == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
    endtask

    task automatic send_kind(input logic [1:0] k);
        send_word(rand_item(k), 1'b0, '0);
    endtask

    task automatic drain();
        push <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic load_gains(input t_gains gv);
        n_gain_sets++;
        for (int i = 0; i < NumGains; i++) begin
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b1;
            paddr   <= 5'(4 * i);
            pwdata  <= gv[i];
            @(posedge i_clk);
            penable <= 1'b1;
            do @(posedge i_clk); while (!pready);
            penable <= 1'b0;
            pwrite  <= 1'b0;
            @(posedge i_clk);
            penable <= 1'b1;
            do @(posedge i_clk); while (!pready);
            if (prdata !== gv[i]) begin
                $error("prdata: expected %h, got %h", gv[i], prdata);
                errors++;
            end
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin : stimulus
        t_dir_row dir_tbl [$];
        t_dir_row row;
        t_gains   gv;
        int       sent;
        int       phase;
        int       n;

        for (int i = 0; i < NumGains; i++) gain_tbl[i] = '0;
        for (int i = 0; i < NumStates; i++) state_est[i] = '0;

        row = '{cfg: 1'b0, gains: '0, word: '0, typed: 1'b0, exp: '0};
        row.word = mk_item(KIND_REQ, 0, 0, 0, 0);
        row.typed = 1'b1; row.exp = mk_res(REPLY_INACTIVE, 0); dir_tbl.push_back(row);
        row.word = mk_item(KIND_MEAS, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
        dir_tbl.push_back(row);
        row.typed = 1'b0;
        row.word = mk_item(KIND_TICK, 0, 0, 0, 0); dir_tbl.push_back(row);
        dir_tbl.push_back(row);
        row.typed = 1'b1;
        row.word = mk_item(KIND_START, 0, 0, 0, 0);
        row.exp = mk_res(REPLY_STARTED, 0); dir_tbl.push_back(row);
        row.exp = mk_res(REPLY_ALREADY, 0); dir_tbl.push_back(row);
        row.typed = 1'b0;
        row.word = mk_item(KIND_TICK, 0, 0, 0, 0); dir_tbl.push_back(row);
        row.typed = 1'b1;
        row.word = mk_item(KIND_REQ, 0, 0, 0, 0);
        row.exp = mk_res(REPLY_DRIVES, 1); dir_tbl.push_back(row);
        row.word = mk_item(KIND_MEAS, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
        row.exp = mk_res(REPLY_STORED, 0); dir_tbl.push_back(row);
        row.typed = 1'b0;
        row.cfg = 1'b1;
        row.gains = {{4{32'h7fffffff}}, {4{32'h80000000}}}; dir_tbl.push_back(row);
        row.cfg = 1'b0;
        row.word = mk_item(KIND_REQ, 0, 0, 0, 0); dir_tbl.push_back(row);
        row.typed = 1'b1;
        row.word = mk_item(KIND_MEAS, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000);
        dir_tbl.push_back(row);
        row.typed = 1'b0;
        row.word = mk_item(KIND_REQ, 0, 0, 0, 0); dir_tbl.push_back(row);
        row.cfg = 1'b1;
        row.gains = {{4{32'hffff0000}}, {4{32'h00010000}}}; dir_tbl.push_back(row);
        row.cfg = 1'b0;
        row.word = mk_item(KIND_MEAS, 32'h00010000, 32'hffff0000, 32'h7fffffff, 32'h80000000);
        dir_tbl.push_back(row);
        row.word = mk_item(KIND_REQ, 0, 0, 0, 0); dir_tbl.push_back(row);
        row.cfg = 1'b1;
        row.gains = {{4{32'hffffffff}}, {4{32'h00000001}}}; dir_tbl.push_back(row);
        row.cfg = 1'b0;
        row.word = mk_item(KIND_MEAS, 1, 1, 1, 1); dir_tbl.push_back(row);
        row.word = mk_item(KIND_REQ, 0, 0, 0, 0); dir_tbl.push_back(row);
        row.word = mk_item(KIND_TICK, 0, 0, 0, 0); dir_tbl.push_back(row);
        row.word = mk_item(KIND_REQ, 0, 0, 0, 0); dir_tbl.push_back(row);

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_tbl[i]) begin
            if (dir_tbl[i].cfg) begin
                drain();
                load_gains(dir_tbl[i].gains);
            end else begin
                send_word(dir_tbl[i].word, dir_tbl[i].typed, dir_tbl[i].exp);
            end
        end

        sent = 0;
        phase = 0;
        while (sent < NUM_RANDOM) begin
            if (sent >= phase * PHASE_LEN) begin
                drain();
                for (int i = 0; i < NumGains; i++) gv[i] = rand_fixed();
                load_gains(gv);
                phase++;
            end
            if (sent == PHASE_LEN + PHASE_LEN / 2) begin
                drain();
            end
            if (sent >= NUM_RANDOM - 150) begin
                calm = 1'b1;
            end
            if ($urandom_range(0, 9) < 7) begin
                n = $urandom_range(0, 3);
                repeat (n) send_kind(KIND_TICK);
                send_kind(KIND_MEAS);
                send_kind(KIND_REQ);
                sent += n + 2;
                if ($urandom_range(0, 1) == 0) begin
                    send_kind(KIND_REQ);
                    sent++;
                end
            end else begin
                send_kind(2'($urandom_range(0, 3)));
                sent++;
            end
        end

        push <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);

        $display("Run covered %0d ticks, %0d starts, %0d measurements, %0d requests.",
                 n_ticks, n_starts, n_meas, n_reqs);
        $display("%0d result words checked, %0d with a saturated drive, %0d gain sets.",
                 n_checked, n_saturated, n_gain_sets);
        if (errors == 0) begin
            $display("** lqr_state_feedback_controller: PASSED **");
        end else begin
            $display("** lqr_state_feedback_controller: FAILED **");
        end
        $finish;
    end

endmodule
